// ----- hw/rtl/udp_hp_pkg.sv -----
package udp_hp_pkg;

  // Frame byte counter and captured length widths
  localparam int unsigned PosW = 16;
  localparam int unsigned LenW = PosW + 1;

  // Frame layout
  localparam int unsigned EthHdrBytes   = 14;
  localparam int unsigned IpMinBytes    = 20;
  localparam int unsigned IpMinWords    = 5;
  localparam int unsigned UdpHdrBytes   = 8;
  localparam int unsigned UdpFieldBytes = 6;
  localparam int unsigned IhlByte       = 14;
  localparam int unsigned ProtoByte     = 23;
  localparam logic [7:0]  ProtoUdp      = 8'd17;

  typedef enum logic [2:0] {
    STATUS_OK         = 3'd0,
    STATUS_SHORT_ETH  = 3'd1,
    STATUS_SHORT_IP   = 3'd2,
    STATUS_BAD_HLEN   = 3'd3,
    STATUS_SHORT_OPTS = 3'd4,
    STATUS_NOT_UDP    = 3'd5,
    STATUS_SHORT_UDP  = 3'd6
  } status_e;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } frame_byte_t;

  typedef struct packed {
    status_e     status;
    logic [15:0] source_port;
    logic [15:0] destination_port;
    logic [15:0] datagram_length;
  } result_t;

endpackage

// ----- hw/rtl/udp_hp_if.sv -----
interface udp_hp_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface udp_hp_result_if import udp_hp_pkg::*;;
  logic        valid;
  logic        ready;
  status_e     status;
  logic [15:0] source_port;
  logic [15:0] destination_port;
  logic [15:0] datagram_length;

  modport source (output valid, output status, output source_port,
                  output destination_port, output datagram_length, input ready);
  modport sink   (input valid, input status, input source_port,
                  input destination_port, input datagram_length, output ready);
endinterface

// ----- hw/rtl/udp_hp_in_stage.sv -----
module udp_hp_in_stage import udp_hp_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        valid_i,
  output logic        ready_o,
  input  frame_byte_t byte_i,
  output logic        valid_o,
  input  logic        take_i,
  output frame_byte_t byte_o
);

  logic        valid_q, valid_d;
  frame_byte_t byte_q;
  logic        accept;

  // Free slot, or the held byte leaves this cycle
  assign ready_o = !valid_q || take_i;
  assign accept  = valid_i && ready_o;

  always_comb begin
    valid_d = valid_q;
    if (accept) begin
      valid_d = 1'b1;
    end else if (take_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Load payload on each accepted transaction
  always_ff @(posedge clk_i) begin
    if (accept) begin
      byte_q <= byte_i;
    end
  end

  assign valid_o = valid_q;
  assign byte_o  = byte_q;

endmodule

// ----- hw/rtl/udp_hp_parse.sv -----
module udp_hp_parse import udp_hp_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        valid_i,
  input  frame_byte_t byte_i,
  input  logic        out_free_i,
  output logic        take_o,
  output logic        res_valid_o,
  output result_t     result_o
);

  logic [PosW-1:0] pos_q, pos_d;
  logic [3:0]      hw_q, hw_d;
  logic [7:0]      proto_q, proto_d;
  logic [15:0]     src_q, src_d;
  logic [15:0]     dst_q, dst_d;
  logic [15:0]     ulen_q, ulen_d;

  logic [6:0]      udp_start;
  logic [LenW-1:0] rel;
  logic            in_win;
  logic [2:0]      off;
  logic [LenW-1:0] len;
  logic [LenW-1:0] ip_bytes;
  status_e         status;
  logic [7:0]      b;
  logic            fire_last;

  assign b = byte_i.data_byte;

  // A last byte needs a free result slot; other bytes always pass
  assign take_o    = valid_i && (!byte_i.last_byte || out_free_i);
  assign fire_last = take_o && byte_i.last_byte;

  // UDP field window starts after the IP header
  assign udp_start = 7'(EthHdrBytes) + {1'b0, hw_q, 2'b00};
  assign rel       = {1'b0, pos_q} - {{(LenW-7){1'b0}}, udp_start};
  assign in_win    = (pos_q > PosW'(IhlByte)) && !rel[LenW-1] &&
                     (rel[PosW-1:0] < PosW'(UdpFieldBytes));
  assign off       = rel[2:0];

  // Next state of the header capture
  always_comb begin
    hw_d    = hw_q;
    proto_d = proto_q;
    src_d   = src_q;
    dst_d   = dst_q;
    ulen_d  = ulen_q;
    if (pos_q == PosW'(IhlByte)) begin
      hw_d = b[3:0];
    end
    if (pos_q == PosW'(ProtoByte)) begin
      proto_d = b;
    end
    if (in_win) begin
      if (off < 3'd2) begin
        src_d = {src_q[7:0], b};
      end else if (off < 3'd4) begin
        dst_d = {dst_q[7:0], b};
      end else begin
        ulen_d = {ulen_q[7:0], b};
      end
    end
    // Saturate the byte counter
    pos_d = (pos_q == '1) ? pos_q : pos_q + PosW'(1);
  end

  // Classify the frame in check order
  assign len      = {1'b0, pos_q} + LenW'(1);
  assign ip_bytes = {{(LenW-6){1'b0}}, hw_d, 2'b00};

  always_comb begin
    if (len < LenW'(EthHdrBytes)) begin
      status = STATUS_SHORT_ETH;
    end else if (len < LenW'(EthHdrBytes + IpMinBytes)) begin
      status = STATUS_SHORT_IP;
    end else if (hw_d < 4'(IpMinWords)) begin
      status = STATUS_BAD_HLEN;
    end else if (len < LenW'(EthHdrBytes) + ip_bytes) begin
      status = STATUS_SHORT_OPTS;
    end else if (proto_d != ProtoUdp) begin
      status = STATUS_NOT_UDP;
    end else if (len < LenW'(EthHdrBytes + UdpHdrBytes) + ip_bytes) begin
      status = STATUS_SHORT_UDP;
    end else begin
      status = STATUS_OK;
    end
  end

  always_comb begin
    result_o.status           = status;
    result_o.source_port      = (status == STATUS_OK) ? src_d  : 16'd0;
    result_o.destination_port = (status == STATUS_OK) ? dst_d  : 16'd0;
    result_o.datagram_length  = (status == STATUS_OK) ? ulen_d : 16'd0;
  end

  assign res_valid_o = fire_last;

  // Advance per byte, clear after the last byte
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q   <= '0;
      hw_q    <= '0;
      proto_q <= '0;
      src_q   <= '0;
      dst_q   <= '0;
      ulen_q  <= '0;
    end else if (fire_last) begin
      pos_q   <= '0;
      hw_q    <= '0;
      proto_q <= '0;
      src_q   <= '0;
      dst_q   <= '0;
      ulen_q  <= '0;
    end else if (take_o) begin
      pos_q   <= pos_d;
      hw_q    <= hw_d;
      proto_q <= proto_d;
      src_q   <= src_d;
      dst_q   <= dst_d;
      ulen_q  <= ulen_d;
    end
  end

`ifndef SYNTHESIS
  a_clear_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire_last |=> (pos_q == '0) && (hw_q == '0) && (proto_q == '0))
    else $error("parser state not cleared after last byte");

  a_count_advance: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (take_o && !byte_i.last_byte && (pos_q != '1)) |=> (pos_q == $past(pos_q) + PosW'(1)))
    else $error("byte counter did not advance");

  a_count_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !take_o |=> $stable(pos_q))
    else $error("byte counter moved without a transaction");

  a_fields_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire_last && (status != STATUS_OK)) |->
      (result_o.source_port == 16'd0) && (result_o.destination_port == 16'd0) &&
      (result_o.datagram_length == 16'd0))
    else $error("error result carries nonzero fields");
`endif

endmodule

// ----- hw/rtl/udp_hp_out_stage.sv -----
module udp_hp_out_stage import udp_hp_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    valid_i,
  input  result_t result_i,
  output logic    free_o,
  output logic    valid_o,
  input  logic    ready_i,
  output result_t result_o
);

  logic    valid_q, valid_d;
  result_t result_q;

  // Slot is free when empty or drained this cycle
  assign free_o = !valid_q || ready_i;

  always_comb begin
    valid_d = valid_q;
    if (valid_i) begin
      valid_d = 1'b1;
    end else if (ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i) begin
      result_q <= result_i;
    end
  end

  assign valid_o  = valid_q;
  assign result_o = result_q;

endmodule

// ----- hw/rtl/udp_header_parser.sv -----
// Stages: input register, parser, result register; a result is valid the cycle
//   after the parser takes its last byte, and can be taken at the following edge.
// Throughput: one frame byte per cycle; a last byte waits only while the
//   result register holds an untaken result.
// Reset: asynchronous, active low; clears the valid flags and all parser
//   state (byte counter, header length, protocol, captured UDP fields).
module udp_header_parser import udp_hp_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  udp_hp_byte_if.sink            frame_i,
  udp_hp_result_if.source        result_o
);

  frame_byte_t in_byte;
  frame_byte_t s1_byte;
  logic        s1_valid;
  logic        take;
  logic        res_valid;
  logic        out_free;
  result_t     res;
  result_t     out_res;

  assign in_byte.data_byte = frame_i.data_byte;
  assign in_byte.last_byte = frame_i.last_byte;

  udp_hp_in_stage u_in_stage (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (frame_i.valid),
    .ready_o (frame_i.ready),
    .byte_i  (in_byte),
    .valid_o (s1_valid),
    .take_i  (take),
    .byte_o  (s1_byte)
  );

  udp_hp_parse u_parse (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (s1_valid),
    .byte_i      (s1_byte),
    .out_free_i  (out_free),
    .take_o      (take),
    .res_valid_o (res_valid),
    .result_o    (res)
  );

  udp_hp_out_stage u_out_stage (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (res_valid),
    .result_i (res),
    .free_o   (out_free),
    .valid_o  (result_o.valid),
    .ready_i  (result_o.ready),
    .result_o (out_res)
  );

  assign result_o.status           = out_res.status;
  assign result_o.source_port      = out_res.source_port;
  assign result_o.destination_port = out_res.destination_port;
  assign result_o.datagram_length  = out_res.datagram_length;

endmodule
